[design/label_volume_dual_contour_macros.svh]
// Assertion helpers for the label volume dual contour block.
`ifndef LABEL_VOLUME_DUAL_CONTOUR_MACROS_SVH
`define LABEL_VOLUME_DUAL_CONTOUR_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define LVDC_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define LVDC_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[design/lvdc_pkg.sv]
package lvdc_pkg;
	localparam int CW = 9;
	localparam int LBW = 16;
	localparam int VNW = 25;
	localparam int CFG_IW = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FPW = 2;
	localparam int OCW = 3;

	localparam logic [CFG_IW-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IW-1:0] REG_SIZE_Z = 2'd2;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_QUAD = 1'b1;

	typedef struct packed {
		logic [CW-1:0] pos_x;
		logic [CW-1:0] pos_y;
		logic [CW-1:0] pos_z;
		logic [VNW-1:0] vn;
		logic [LBW-1:0] lab0;
		logic [LBW-1:0] lab1;
		logic [LBW-1:0] lab2;
		logic [LBW-1:0] lab3;
		logic [VNW-1:0] n_rx;
		logic [VNW-1:0] n_prx;
		logic [VNW-1:0] n_p;
		logic [VNW-1:0] n_p1;
		logic [VNW-1:0] n_1;
		logic [VNW-1:0] n_rx1;
		logic [2:0] mask;
	} bundle_t;
endpackage

[design/label_volume_dual_contour.sv]
// The block takes one label word per padded grid position, x fastest, over positions 0..X,
// 0..Y, 0..Z, and for every cell whose eight corner labels differ gives a vertex word followed
// by up to three quad words; the last word of each voxel carries last. Each voxel passes through
// the four-phase read sequence over the label and vertex memories, each with two read ports and
// one write port; the next voxel can be taken in the last phase. Results drain at one word per
// cycle while result_stall is low, through a four-entry buffer. After reset the label memory is
// cleared, one entry per cycle, over (DIM_MAX+1)*(DIM_MAX+2)+1 entries (66307 at the default);
// after each configuration write it recomputes its memory addressing; input is stalled during both.
`include "label_volume_dual_contour_macros.svh"

module label_volume_dual_contour #(
	parameter int DIM_MAX = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lvdc_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [lvdc_pkg::CW-1:0]           cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [lvdc_pkg::LBW-1:0]          label,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              kind,
	output logic [lvdc_pkg::CW-1:0]           pos_x,
	output logic [lvdc_pkg::CW-1:0]           pos_y,
	output logic [lvdc_pkg::CW-1:0]           pos_z,
	output logic [lvdc_pkg::VNW-1:0]          corner_a,
	output logic [lvdc_pkg::VNW-1:0]          corner_b,
	output logic [lvdc_pkg::VNW-1:0]          corner_c,
	output logic [lvdc_pkg::VNW-1:0]          corner_d,
	output logic [lvdc_pkg::LBW-1:0]          label_low,
	output logic [lvdc_pkg::LBW-1:0]          label_high,
	output logic                              last
);
	localparam int DEPTH = (DIM_MAX + 1) * (DIM_MAX + 2) + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = lvdc_pkg::CW;
	localparam int RXW = CW + 1;
	localparam int BW = $clog2(RXW);
	localparam int PW = 2 * RXW;
	localparam int LBW = lvdc_pkg::LBW;
	localparam int VNW = lvdc_pkg::VNW;
	localparam int OCW = lvdc_pkg::OCW;
	localparam int FPW = lvdc_pkg::FPW;
	localparam logic [OCW-1:0] FD_OCC = OCW'(lvdc_pkg::FIFO_DEPTH);

	typedef logic [AW-1:0] addr_t;
	typedef enum logic [1:0] {RC_IDLE, RC_PREP, RC_MUL, RC_FIN} rc_state_t;

	function automatic addr_t add_mod(addr_t a, addr_t b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic addr_t sub_mod(addr_t a, addr_t b);
		logic [AW:0] s;
		s = {1'b0, a} - {1'b0, b};
		if (s[AW]) s = s + (AW + 1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [CW-1:0] eff_size(logic [CW-1:0] v);
		if (v == '0) return CW'(1);
		if (32'(v) > DIM_MAX) return CW'(DIM_MAX);
		return v;
	endfunction

	function automatic logic [CW-1:0] half_pos(logic [CW-1:0] c, logic [CW-1:0] s);
		logic [CW:0] h;
		logic [CW:0] top;
		h = (c == '0) ? '0 : ({c, 1'b0} - (CW + 1)'(1));
		top = {s, 1'b0} - (CW + 1)'(2);
		return (h > top) ? top[CW-1:0] : h[CW-1:0];
	endfunction

	// Configuration
	logic [CW-1:0] size_x_q, size_y_q, size_z_q;
	logic [CW-1:0] sx, sy, sz;
	logic [RXW-1:0] sxp1, syp1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CW'(1);
			size_y_q <= CW'(1);
			size_z_q <= CW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				lvdc_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				lvdc_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				lvdc_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sx = eff_size(size_x_q);
	assign sy = eff_size(size_y_q);
	assign sz = eff_size(size_z_q);
	assign sxp1 = RXW'(sx) + RXW'(1);
	assign syp1 = RXW'(sy) + RXW'(1);

	// Control declarations
	logic clr_busy_q;
	addr_t clr_addr_q;
	logic busy_q;
	logic [1:0] ph_q;
	logic eval_v_s2;
	logic [OCW-1:0] occ_q;
	logic [OCW-1:0] cnt_q;
	rc_state_t rc_q;
	logic item_acc;
	logic push, pop;
	logic has_vtx;

	assign item_stall = !(!clr_busy_q && rc_q == RC_IDLE && !cfg_we && occ_q < FD_OCC &&
		(!busy_q || ph_q == 2'd3));
	assign item_acc = item_valid && !item_stall;

	// Scan position and address recompute
	logic [CW-1:0] x_q, y_q, z_q;
	addr_t here_q, row_base_q, plane_base_q;
	logic [RXW-1:0] rx_q;
	addr_t plane_q, trow_q, yrx_q, acc_q;
	addr_t off_rx_q, off_rx1_q, off_p_q, off_p1_q, off_prx_q, off_prx1_q;
	logic [BW-1:0] bit_q;
	logic x_end, y_end, z_end;
	addr_t row_next, plane_next, acc_dbl, acc_next;

	assign x_end = x_q >= sx;
	assign y_end = y_q >= sy;
	assign z_end = z_q >= sz;
	assign row_next = add_mod(row_base_q, AW'(rx_q));
	assign plane_next = add_mod(plane_base_q, plane_q);
	assign acc_dbl = add_mod(acc_q, acc_q);
	assign acc_next = rx_q[bit_q] ? add_mod(acc_dbl, trow_q) : acc_dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= RC_IDLE;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			here_q <= '0;
			row_base_q <= '0;
			plane_base_q <= '0;
			rx_q <= RXW'(2);
			plane_q <= AW'(4);
			off_rx_q <= AW'(2);
			off_rx1_q <= AW'(3);
			off_p_q <= AW'(4);
			off_p1_q <= AW'(5);
			off_prx_q <= AW'(6);
			off_prx1_q <= AW'(7);
			trow_q <= '0;
			yrx_q <= '0;
			acc_q <= '0;
			bit_q <= '0;
		end else if (cfg_we) begin
			rc_q <= RC_PREP;
		end else begin
			case (rc_q)
				RC_PREP: begin
					rx_q <= sxp1;
					plane_q <= AW'(PW'(sxp1) * PW'(syp1));
					trow_q <= AW'(PW'(z_q) * PW'(syp1) + PW'(y_q));
					yrx_q <= AW'(PW'(y_q) * PW'(sxp1));
					acc_q <= '0;
					bit_q <= BW'(RXW - 1);
					rc_q <= RC_MUL;
				end
				RC_MUL: begin
					acc_q <= acc_next;
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) rc_q <= RC_FIN;
				end
				RC_FIN: begin
					row_base_q <= acc_q;
					plane_base_q <= sub_mod(acc_q, yrx_q);
					here_q <= add_mod(acc_q, AW'(x_q));
					off_rx_q <= AW'(rx_q);
					off_rx1_q <= AW'(rx_q) + AW'(1);
					off_p_q <= plane_q;
					off_p1_q <= plane_q + AW'(1);
					off_prx_q <= plane_q + AW'(rx_q);
					off_prx1_q <= plane_q + AW'(rx_q) + AW'(1);
					rc_q <= RC_IDLE;
				end
				default: begin
					if (item_acc) begin
						if (!x_end) begin
							x_q <= x_q + CW'(1);
							here_q <= add_mod(here_q, AW'(1));
						end else if (!y_end) begin
							x_q <= '0;
							y_q <= y_q + CW'(1);
							row_base_q <= row_next;
							here_q <= row_next;
						end else if (!z_end) begin
							x_q <= '0;
							y_q <= '0;
							z_q <= z_q + CW'(1);
							plane_base_q <= plane_next;
							row_base_q <= plane_next;
							here_q <= plane_next;
						end else begin
							x_q <= '0;
							y_q <= '0;
							z_q <= '0;
							plane_base_q <= '0;
							row_base_q <= '0;
							here_q <= '0;
						end
					end
				end
			endcase
		end
	end

	// Item stages
	addr_t here_s1, here_s2;
	logic gx_s1, gy_s1, gz_s1, gx_s2, gy_s2, gz_s2;
	logic [LBW-1:0] cur_s1, cur_s2;
	logic [CW-1:0] px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2;
	logic wrap_s1, wrap_s2;
	logic last_ph;

	assign last_ph = busy_q && ph_q == 2'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= '0;
			eval_v_s2 <= 1'b0;
		end else begin
			eval_v_s2 <= last_ph;
			if (item_acc) begin
				busy_q <= 1'b1;
				ph_q <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			here_s1 <= here_q;
			gx_s1 <= x_q != '0;
			gy_s1 <= y_q != '0;
			gz_s1 <= z_q != '0;
			cur_s1 <= (x_end || y_end || z_end) ? '0 : label;
			px_s1 <= half_pos(x_q, sx);
			py_s1 <= half_pos(y_q, sy);
			pz_s1 <= half_pos(z_q, sz);
			wrap_s1 <= x_end && y_end && z_end;
		end
		if (last_ph) begin
			here_s2 <= here_s1;
			gx_s2 <= gx_s1;
			gy_s2 <= gy_s1;
			gz_s2 <= gz_s1;
			cur_s2 <= cur_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
			wrap_s2 <= wrap_s1;
		end
	end

	// Memories
	addr_t loff_a, loff_b, voff_a, voff_b;
	logic lwe;
	addr_t lwa;
	logic [LBW-1:0] lwd, lrd_a, lrd_b;
	logic [VNW-1:0] vrd_a, vrd_b, vcount_q;

	always_comb begin
		case (ph_q)
			2'd0: begin
				loff_a = off_prx1_q;
				loff_b = off_prx_q;
				voff_a = AW'(1);
				voff_b = AW'(1);
			end
			2'd1: begin
				loff_a = off_p1_q;
				loff_b = off_rx1_q;
				voff_a = off_rx_q;
				voff_b = off_prx_q;
			end
			2'd2: begin
				loff_a = off_p_q;
				loff_b = AW'(1);
				voff_a = off_p_q;
				voff_b = off_p1_q;
			end
			default: begin
				loff_a = off_rx_q;
				loff_b = AW'(1);
				voff_a = AW'(1);
				voff_b = off_rx1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	assign lwe = clr_busy_q || (busy_q && ph_q == 2'd0);
	assign lwa = clr_busy_q ? clr_addr_q : here_s1;
	assign lwd = clr_busy_q ? '0 : cur_s1;

	lvdc_ram #(.WIDTH(LBW), .DEPTH(DEPTH), .ADDR_W(AW)) u_label_ram (
		.clk  (clk),
		.we   (lwe),
		.wa   (lwa),
		.wd   (lwd),
		.ra_a (sub_mod(here_s1, loff_a)),
		.ra_b (sub_mod(here_s1, loff_b)),
		.rd_a (lrd_a),
		.rd_b (lrd_b)
	);

	lvdc_ram #(.WIDTH(VNW), .DEPTH(DEPTH), .ADDR_W(AW)) u_vertex_ram (
		.clk  (clk),
		.we   (push),
		.wa   (here_s2),
		.wd   (vcount_q),
		.ra_a (sub_mod(here_s1, voff_a)),
		.ra_b (sub_mod(here_s1, voff_b)),
		.rd_a (vrd_a),
		.rd_b (vrd_b)
	);

	// Read data capture
	logic [LBW-1:0] l0_q, l1_q, l2_q, l3_q, l4_q, l5_q;
	logic [VNW-1:0] vrx_q, vprx_q, vp_q, vp1_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			case (ph_q)
				2'd1: begin
					l0_q <= lrd_a;
					l1_q <= lrd_b;
				end
				2'd2: begin
					l2_q <= lrd_a;
					l3_q <= lrd_b;
					vrx_q <= vrd_a;
					vprx_q <= vrd_b;
				end
				2'd3: begin
					l4_q <= lrd_a;
					l5_q <= lrd_b;
					vp_q <= vrd_a;
					vp1_q <= vrd_b;
				end
				default: ;
			endcase
		end
	end

	// Cell evaluation
	logic [LBW-1:0] e0, e1, e2, e3, e4, e5, e6;
	logic [2:0] qmask;

	assign e0 = (gx_s2 && gy_s2 && gz_s2) ? l0_q : '0;
	assign e1 = (gy_s2 && gz_s2) ? l1_q : '0;
	assign e2 = (gx_s2 && gz_s2) ? l2_q : '0;
	assign e3 = (gx_s2 && gy_s2) ? l3_q : '0;
	assign e4 = gz_s2 ? l4_q : '0;
	assign e5 = gx_s2 ? l5_q : '0;
	assign e6 = gy_s2 ? lrd_a : '0;
	assign qmask = {e0 != e3, e0 != e2, e0 != e1};
	assign has_vtx = qmask != '0 || e0 != e4 || e0 != e5 || e0 != e6 || e0 != cur_s2;
	assign push = eval_v_s2 && has_vtx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (eval_v_s2) begin
			if (wrap_s2) vcount_q <= '0;
			else if (has_vtx) vcount_q <= vcount_q + VNW'(1);
		end
	end

	// Result buffer
	lvdc_pkg::bundle_t fifo_q [lvdc_pkg::FIFO_DEPTH];
	lvdc_pkg::bundle_t head;
	logic [FPW-1:0] wp_q, rp_q;
	logic vdone_q;
	logic [2:0] taken_q, rem, sel;
	logic res_acc, rem_single;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{pos_x: px_s2, pos_y: py_s2, pos_z: pz_s2, vn: vcount_q,
				lab0: e0, lab1: e1, lab2: e2, lab3: e3,
				n_rx: vrx_q, n_prx: vprx_q, n_p: vp_q, n_p1: vp1_q,
				n_1: vrd_a, n_rx1: vrd_b, mask: qmask};
		end
	end

	assign head = fifo_q[rp_q];
	assign rem = head.mask & ~taken_q;
	assign sel = rem[0] ? 3'b001 : (rem[1] ? 3'b010 : 3'b100);
	assign rem_single = (rem & (rem - 3'd1)) == '0;
	assign result_valid = cnt_q != '0;
	assign res_acc = result_valid && !result_stall;
	assign pop = res_acc && (vdone_q ? rem_single : head.mask == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			occ_q <= '0;
			vdone_q <= 1'b0;
			taken_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + FPW'(1);
			if (pop) begin
				rp_q <= rp_q + FPW'(1);
				vdone_q <= 1'b0;
				taken_q <= '0;
			end else if (res_acc) begin
				if (vdone_q) taken_q <= taken_q | sel;
				else vdone_q <= 1'b1;
			end
			cnt_q <= cnt_q + OCW'(push) - OCW'(pop);
			occ_q <= occ_q + OCW'(item_acc) - OCW'(eval_v_s2 && !has_vtx) - OCW'(pop);
		end
	end

	// Result fields
	logic [LBW-1:0] qa, qb;
	logic [VNW-1:0] n1, n2, n3;
	logic swap;

	always_comb begin
		qa = head.lab0;
		case (sel)
			3'b001: begin
				qb = head.lab1;
				n1 = head.n_rx;
				n2 = head.n_prx;
				n3 = head.n_p;
			end
			3'b010: begin
				qb = head.lab2;
				n1 = head.n_p;
				n2 = head.n_p1;
				n3 = head.n_1;
			end
			default: begin
				qb = head.lab3;
				n1 = head.n_1;
				n2 = head.n_rx1;
				n3 = head.n_rx;
			end
		endcase
		swap = qa < qb;
		if (vdone_q) begin
			kind = lvdc_pkg::KIND_QUAD;
			pos_x = '0;
			pos_y = '0;
			pos_z = '0;
			corner_a = swap ? n3 : head.vn;
			corner_b = swap ? n2 : n1;
			corner_c = swap ? n1 : n2;
			corner_d = swap ? head.vn : n3;
			label_low = swap ? qa : qb;
			label_high = swap ? qb : qa;
			last = rem_single;
		end else begin
			kind = lvdc_pkg::KIND_VERTEX;
			pos_x = head.pos_x;
			pos_y = head.pos_y;
			pos_z = head.pos_z;
			corner_a = head.vn;
			corner_b = '0;
			corner_c = '0;
			corner_d = '0;
			label_low = '0;
			label_high = '0;
			last = head.mask == '0;
		end
	end

	`LVDC_ASSERT_ALWAYS(a_occ_bound, occ_q <= FD_OCC, "items in flight exceed buffer")
	`LVDC_ASSERT_IMPLY(a_push_room, push, cnt_q < FD_OCC, "result buffer overrun")
	`LVDC_ASSERT_IMPLY(a_clear_quiet, clr_busy_q, !busy_q && !eval_v_s2, "item during clear")
endmodule

[design/lvdc_ram.sv]
module lvdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [WIDTH-1:0]  wd,
	input  logic [ADDR_W-1:0] ra_a,
	input  logic [ADDR_W-1:0] ra_b,
	output logic [WIDTH-1:0]  rd_a,
	output logic [WIDTH-1:0]  rd_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a <= mem[ra_a];
		rd_b <= mem[ra_b];
	end
endmodule
